// File: design/rau_pkg.sv
// rau_pkg: constants shared by the rational arithmetic unit.
// No dependencies.
package rau_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERODEN = 2'd1;
    localparam logic [1:0] ST_UNDEF   = 2'd2;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
endpackage

// File: design/rational_arith_unit_core.sv
// rational_arith_unit_core: exact add/sub/mul/div of two signed fractions
// with GCD reduction. Depends on rau_pkg.
//
// Usage:
//   Drive i_start with the opcode and both fractions; the edge with i_start
//   high and o_busy low accepts the input word. o_busy stays high until the
//   result word shows on o_result_num / o_result_den / o_status for one
//   cycle, marked by o_done. The receiver cannot stall; o_done lasts one cycle.
// Sequence, from the accepted word to the result: cross products through one
//   shared multiplier (three products, then the denominator store), a
//   magnitude step, then a binary GCD on the magnitudes through one shared
//   subtract/compare/shift unit, closing once either value is zero, then two
//   restoring divisions by the GCD, one quotient bit per cycle through the
//   same subtractor, then the output state, from which o_done is registered.
//   Zero over zero (a zero GCD) ends both divisions after their first step.
//   o_busy falls as o_done rises, so a new word can be accepted at the edge
//   that takes the result.
// Zero over zero gives 0/0 with status 2; zero denominator gives +-1/0
//   with status 1; a zero numerator gives 0/1.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
//   o_done; a word in flight is dropped.
module rational_arith_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_done,
    output logic signed [NUM_OUT_W-1:0]     o_result_num,
    output logic [DEN_OUT_W-1:0]            o_result_den,
    output logic [1:0]                      o_status
);
    localparam int PW = 2 * OPERAND_WIDTH;   // product width
    localparam int MW = PW + 1;              // magnitude width (sum may grow)
    localparam int CW = $clog2(MW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_MUL3 = 4'd4;
    localparam logic [3:0] S_MAG  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] r_state, n_state;

    // operands
    logic [1:0]                      r_op;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;

    // shared multiplier: one product per cycle, registered
    logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic signed [PW-1:0]            mul_p;
    logic signed [PW-1:0]            r_p;
    logic signed [MW-1:0]            r_rn, r_rd;

    // gcd / divide working registers
    logic [MW-1:0] r_mn, r_md;     // magnitudes kept for division
    logic [MW-1:0] r_x, r_y;
    logic [CW-1:0] r_k;            // common power of two
    logic [MW-1:0] r_g;
    logic [MW-1:0] r_rem, r_quo, r_qn;
    logic [CW-1:0] r_cnt;
    logic          r_neg;

    logic              r_done;
    logic [NUM_OUT_W-1:0] r_onum;
    logic [DEN_OUT_W-1:0] r_oden;
    logic [1:0]        r_ostat;

    // the one shared subtractor
    logic [MW-1:0] sub_a, sub_b;
    logic [MW:0]   sub_d;
    assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (r_state)
            S_MUL0: begin mul_a = r_an; mul_b = (r_op == OP_MUL) ? r_bn : r_bd; end
            S_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            S_MUL2: begin
                mul_a = r_ad;
                mul_b = (r_op == OP_DIV) ? r_bn : r_bd;
            end
            default: begin mul_a = r_an; mul_b = r_bd; end
        endcase
    end

    logic [MW-1:0] rem_sh;
    always_comb begin
        sub_a = r_x;
        sub_b = r_y;
        rem_sh = '0;
        case (r_state)
            S_GCD: begin
                if (r_x >= r_y) begin sub_a = r_x; sub_b = r_y; end
                else begin sub_a = r_y; sub_b = r_x; end
            end
            S_DIVN: begin
                rem_sh = {r_rem[MW-2:0], r_mn[MW-1]};
                sub_a = rem_sh;
                sub_b = r_g;
            end
            S_DIVD: begin
                rem_sh = {r_rem[MW-2:0], r_md[MW-1]};
                sub_a = rem_sh;
                sub_b = r_g;
            end
            default: begin sub_a = r_x; sub_b = r_y; end
        endcase
    end

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        mag = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_OUT);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_MAG;
            S_MAG:  n_state = S_GCD;
            S_GCD: begin
                if (r_x == '0 || r_y == '0) n_state = S_DIVN;
            end
            S_DIVN: if (r_cnt == CW'(MW - 1) || r_g == '0) n_state = S_DIVD;
            S_DIVD: if (r_cnt == CW'(MW - 1) || r_g == '0) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op <= i_opcode;
                r_an <= i_a_num;
                r_ad <= i_a_den;
                r_bn <= i_b_num;
                r_bd <= i_b_den;
            end
            S_MUL0: r_p <= mul_p;
            S_MUL1: begin
                r_rn <= MW'(r_p);
                r_p  <= mul_p;
            end
            S_MUL2: begin
                case (r_op)
                    OP_ADD: r_rn <= r_rn + MW'(r_p);
                    OP_SUB: r_rn <= r_rn - MW'(r_p);
                    default: r_rn <= r_rn;
                endcase
                r_p <= mul_p;
            end
            S_MUL3: r_rd <= MW'(r_p);
            S_MAG: begin
                r_mn  <= mag(r_rn);
                r_md  <= mag(r_rd);
                r_x   <= mag(r_rn);
                r_y   <= mag(r_rd);
                r_k   <= '0;
                r_neg <= r_rn[MW-1] ^ r_rd[MW-1];
            end
            S_GCD: begin
                // binary GCD step
                if (r_x == '0 || r_y == '0) begin
                    r_g   <= (r_x | r_y) << r_k;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= sub_d[MW-1:0];
                end else begin
                    r_y <= sub_d[MW-1:0];
                end
            end
            S_DIVN: begin
                r_mn <= r_mn << 1;
                if (!sub_d[MW]) begin
                    r_quo <= {r_quo[MW-2:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[MW-2:0], 1'b0};
                end
                if (r_cnt == CW'(MW - 1)) begin
                    // last numerator bit: keep quotient, clear for denominator
                    r_qn  <= !sub_d[MW] ? {r_quo[MW-2:0], 1'b1}
                                         : {r_quo[MW-2:0], 1'b0};
                    r_cnt <= '0;
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_rem <= !sub_d[MW] ? sub_d[MW-1:0] : rem_sh;
                end
            end
            S_DIVD: begin
                r_md <= r_md << 1;
                if (!sub_d[MW]) begin
                    r_rem <= sub_d[MW-1:0];
                    r_quo <= {r_quo[MW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[MW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_OUT: begin
                if (r_g == '0) begin
                    r_onum  <= '0;
                    r_oden  <= '0;
                    r_ostat <= ST_UNDEF;
                end else begin
                    r_onum  <= (r_neg && r_qn != '0) ? NUM_OUT_W'(-r_qn)
                                                      : NUM_OUT_W'(r_qn);
                    r_oden  <= DEN_OUT_W'(r_quo);
                    r_ostat <= (r_quo == '0) ? ST_ZERODEN : ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_status     = r_ostat;

    // --- assertions ---
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_MUL0))
        else $error("start not taken");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("done while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_ZERODEN || o_status == ST_UNDEF))
        else $error("bad status");
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_UNDEF) |-> (o_result_num == '0 && o_result_den == '0))
        else $error("undefined result not zero");
endmodule

// File: test/rational_arith_unit_core_tb.sv
// rational_arith_unit_core_tb: self-checking bench for the rational arithmetic unit.
// Depends on rau_pkg and rational_arith_unit_core; predicts each result word and
// checks it field by field.
module rational_arith_unit_core_tb
    import rau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 16;

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] num;
        logic [DEN_OUT_W-1:0]        den;
        logic [1:0]                  status;
    } t_frac_res;

    // Scoreboard: computes the reduced fraction for each accepted word and
    // matches result words against it in order.
    class t_frac_scoreboard;
        t_frac_res pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned gcd64(longint unsigned x, longint unsigned y);
            longint unsigned r;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function void note_word(logic [1:0] op, logic signed [W-1:0] an,
                                logic signed [W-1:0] ad, logic signed [W-1:0] bn,
                                logic signed [W-1:0] bd);
            longint rn, rd;
            longint unsigned mn, md, g, qn, qd, onum;
            bit neg;
            t_frac_res r;
            case (op)
                OP_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
                OP_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
                OP_MUL: begin rn = an * bn; rd = ad * bd; end
                default: begin rn = an * bd; rd = ad * bn; end
            endcase
            mn = (rn < 0) ? -rn : rn;
            md = (rd < 0) ? -rd : rd;
            g = gcd64(mn, md);
            if (g == 0) begin
                qn = 0; qd = 0; neg = 0;
                r.status = ST_UNDEF;
            end else begin
                qn = mn / g;
                qd = md / g;
                neg = (qn != 0) && ((rn < 0) != (rd < 0));
                r.status = (qd == 0) ? ST_ZERODEN : ST_OK;
            end
            onum = neg ? -qn : qn;
            r.num = onum[NUM_OUT_W-1:0];
            r.den = qd[DEN_OUT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_word(logic signed [NUM_OUT_W-1:0] num,
                                 logic [DEN_OUT_W-1:0] den, logic [1:0] st);
            t_frac_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %0d/%0d st %0d", $time, num, den, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (num !== e.num) begin
                $display("%0t: num exp %0d got %0d", $time, e.num, num);
                errors++;
            end
            if (den !== e.den) begin
                $display("%0t: den exp %0d got %0d", $time, e.den, den);
                errors++;
            end
            if (st !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_start = 0;
    logic [1:0]                  i_opcode = OP_ADD;
    logic signed [W-1:0]         i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic                        o_busy, o_done;
    logic signed [NUM_OUT_W-1:0] o_result_num;
    logic [DEN_OUT_W-1:0]        o_result_den;
    logic [1:0]                  o_status;

    t_frac_scoreboard sb = new();

    rational_arith_unit_core #(.OPERAND_WIDTH(W)) DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Results cannot be stalled; sample every done strobe at the edge.
    always @(posedge i_clk)
        if (i_rst_n && o_done)
            sb.check_word(o_result_num, o_result_den, o_status);

    // Mostly short gaps, occasionally long ones, sometimes none.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 4) ? 0 :
            ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
        repeat (n) @(posedge i_clk);
    endtask

    // Present one word and hold start until an edge with busy low takes it;
    // start drops on the next edge, while the unit is busy anyway.
    task automatic send_word(logic [1:0] op, logic [W-1:0] an, logic [W-1:0] ad,
                             logic [W-1:0] bn, logic [W-1:0] bd);
        i_start  <= 1;
        i_opcode <= op;
        i_a_num  <= an;
        i_a_den  <= ad;
        i_b_num  <= bn;
        i_b_den  <= bd;
        do @(posedge i_clk); while (o_busy);
        sb.note_word(op, an, ad, bn, bd);
        i_start <= 0;
        @(posedge i_clk);
    endtask

    // Wait on edges until every predicted word has come back.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Random operand: full range, corners, or small values so that GCD
    // reduction and zero cases come up often.
    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'sd0;
            3, 4: return 16'($signed($urandom_range(0, 24)) - 12);
            default: return 16'($urandom);
        endcase
    endfunction

    logic [W-1:0] corners[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0006};

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: every op on extremes, zero numerator, zero denominator,
        // zero over zero, and signs needing normalization.
        for (int op = 0; op < 4; op++) begin
            send_word(op[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_word(op[1:0], 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
            send_word(op[1:0], 16'h0000, 16'h0005, 16'h0000, 16'hfffd);
            send_word(op[1:0], 16'h0003, 16'h0000, 16'hfffe, 16'h0000);
            send_word(op[1:0], 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        end
        send_word(OP_DIV, 16'h0004, 16'hfffa, 16'h0000, 16'h0007);
        send_word(OP_SUB, 16'h0001, 16'h0002, 16'h0001, 16'h0002);
        // Hold off until the unit has drained every pending result.
        drain();
        @(posedge i_clk);
        for (int k = 0; k < 1700; k++) begin
            idle_gap();
            if ($urandom_range(0, 9) == 0)
                send_word(2'($urandom_range(0, 3)), corners[$urandom_range(0, 5)],
                          corners[$urandom_range(0, 5)], corners[$urandom_range(0, 5)],
                          corners[$urandom_range(0, 5)]);
            else
                send_word(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                          rand_operand(), rand_operand());
        end
        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0)
            $display("rational_arith_unit_core_tb OK");
        else
            $display("rational_arith_unit_core_tb NOT OK");
        $finish;
    end

    // Worst case, about 1750 items each after the longest gap, is under 9 ms.
    initial begin
        #50ms;
        $display("rational_arith_unit_core_tb NOT OK");
        $finish;
    end
endmodule
